[design/lvs_pkg.sv]
// Shared constants and types for the lattice vorticity stencil.
// No dependencies.
package lvs_pkg;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int POP_BITS_DEF  = 24;
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_W         = 10;
  localparam int HGT_W         = 11;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int COL_MAX_W     = 12;
  localparam int VEL_W         = 19;
  localparam int FRAC_BITS     = 16;
  localparam int VORT_W        = 32;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic                 row_odd;
    logic [COL_MAX_W-1:0] col;
  } node_ctl_t;
endpackage

[design/lvs_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module lvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/lvs_front.sv]
// Front end: configuration registers, raster counters, population sums.
// Depends on lvs_pkg.
module lvs_front import lvs_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int POP_BITS  = POP_BITS_DEF,
  localparam int NUM_W = POP_BITS + 3,
  localparam int DEN_W = POP_BITS + 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       accept,
  input  logic signed [POP_BITS-1:0] pops [9],
  output node_ctl_t                  ctl,
  output logic signed [DEN_W-1:0]    den,
  output logic signed [NUM_W-1:0]    nx,
  output logic signed [NUM_W-1:0]    ny
);
  localparam int WW = $clog2(MAX_WIDTH + 1) + 1;
  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;
  logic [WW-1:0]    w_eff, col_ext;
  logic [HGT_W-1:0] h_eff;

  always_comb begin
    logic signed [DEN_W-1:0] p [9];
    for (int i = 0; i < 9; i++) p[i] = DEN_W'(pops[i]);
    den = p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8];
    nx  = NUM_W'(p[0] + p[1] + p[2] - p[4] - p[5] - p[6]);
    ny  = NUM_W'(p[1] + p[3] + p[5] - p[0] - p[4] - p[7]);
  end

  always_comb begin
    if (grid_width < CFG_W'(3)) w_eff = WW'(3);
    else if (WW'(grid_width) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(grid_width);
    if (grid_height < CFG_W'(3)) h_eff = HGT_W'(3);
    else if (grid_height > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = grid_height;
  end

  assign col_ext = WW'(column_count);

  always_comb begin
    ctl.col     = COL_MAX_W'(column_count);
    ctl.row_odd = row_count[0];
    ctl.emit    = (row_count >= ROW_W'(2)) && (column_count != '0) &&
                  (col_ext + WW'(2) <= w_eff);
    ctl.last    = (HGT_W'(row_count) == h_eff - HGT_W'(1)) &&
                  (col_ext == w_eff - WW'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= WIDTH_RESET;
      grid_height  <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: begin
          grid_width   <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_GRID_HEIGHT: begin
          grid_height  <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (col_ext + WW'(1) >= w_eff) begin
        column_count <= '0;
        if (HGT_W'(row_count) + HGT_W'(1) >= h_eff) row_count <= '0;
        else row_count <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end
endmodule

[design/lvs_queue.sv]
// Two-entry queue between front and back.
// No dependencies.
module lvs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wptr, rptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[design/lvs_back.sv]
// Back end: serial divider, line stores, vorticity and output register.
// Depends on lvs_pkg and lvs_ram.
module lvs_back import lvs_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int POP_BITS  = POP_BITS_DEF,
  localparam int NUM_W = POP_BITS + 3,
  localparam int DEN_W = POP_BITS + 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  node_ctl_t                q_ctl,
  input  logic signed [DEN_W-1:0]  q_den,
  input  logic signed [NUM_W-1:0]  q_nx,
  input  logic signed [NUM_W-1:0]  q_ny,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VORT_W-1:0] vort_value,
  output logic                     density_fault,
  output logic                     frame_last
);
  localparam int DVD_W = NUM_W + FRAC_BITS;
  localparam int IT_W  = $clog2(DVD_W + 1);
  localparam int UXA_W = $clog2(2 * MAX_WIDTH);
  localparam int UYA_W = $clog2(MAX_WIDTH);
  localparam int ENT_W = VEL_W + 1;
  localparam logic [DVD_W-1:0] QMAX = DVD_W'((1 << (VEL_W - 1)) - 1);
  localparam logic signed [VEL_W-1:0] VMAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VMIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD1, S_RD2, S_CALC} state_t;
  state_t state;

  node_ctl_t        ctl;
  logic [IT_W-1:0]  iter;
  logic [DEN_W-1:0] dmag;
  logic [DVD_W-1:0] dvd_x, dvd_y;
  logic [DEN_W:0]   rem_x, rem_y;
  logic             neg_x, neg_y, sgn_nx, sgn_ny, nz_nx, nz_ny, den_zero;
  logic signed [VEL_W-1:0] uy_delay;
  logic             fy_delay;
  logic [ENT_W-1:0] ux_old, uy_old;

  logic             we;
  logic [UXA_W-1:0] ux_addr;
  logic [UYA_W-1:0] uy_waddr, uy_raddr;
  logic [ENT_W-1:0] ux_rdata, uy_rdata, ux_wdata, uy_wdata;
  logic signed [VEL_W-1:0] ux, uy;
  logic             proceed;

  function automatic logic signed [VEL_W-1:0] sat_vel(
    input logic [DVD_W-1:0] q, input logic neg);
    if (neg) begin
      if (q > QMAX + DVD_W'(1)) return VMIN;
      return VEL_W'(-q);
    end
    if (q > QMAX) return VMAX;
    return VEL_W'(q);
  endfunction

  always_comb begin
    ux = sat_vel(dvd_x, neg_x);
    uy = sat_vel(dvd_y, neg_y);
    if (den_zero) begin
      ux = nz_nx ? (sgn_nx ? VMIN : VMAX) : '0;
      uy = nz_ny ? (sgn_ny ? VMIN : VMAX) : '0;
    end
  end

  assign ux_addr  = UXA_W'(ctl.row_odd) * UXA_W'(MAX_WIDTH) + UXA_W'(ctl.col);
  assign uy_waddr = UYA_W'(ctl.col);
  // keep the right neighbor on the read port while the write-back waits
  assign uy_raddr = (state == S_RD2 || state == S_CALC) ?
                    UYA_W'(ctl.col + COL_MAX_W'(1)) : UYA_W'(ctl.col);
  assign ux_wdata = {den_zero, ux};
  assign uy_wdata = {den_zero, uy};
  assign proceed  = (state == S_CALC) && !(out_valid && out_stall);
  assign we       = proceed;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  lvs_ram #(.WIDTH(ENT_W), .DEPTH(2 * MAX_WIDTH)) u_ux_ram (
    .clk(clk), .we(we), .waddr(ux_addr), .wdata(ux_wdata),
    .raddr(ux_addr), .rdata(ux_rdata)
  );

  lvs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WIDTH)) u_uy_ram (
    .clk(clk), .we(we), .waddr(uy_waddr), .wdata(uy_wdata),
    .raddr(uy_raddr), .rdata(uy_rdata)
  );

  always_ff @(posedge clk) begin
    logic [DEN_W:0]          sx, sy;
    logic signed [VEL_W+2:0] d;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      uy_delay  <= '0;
      fy_delay  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(proceed && ctl.emit)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ctl      <= q_ctl;
            dmag     <= q_den[DEN_W-1] ? DEN_W'(-q_den) : DEN_W'(q_den);
            den_zero <= (q_den == '0);
            dvd_x    <= {q_nx[NUM_W-1] ? NUM_W'(-q_nx) : NUM_W'(q_nx), {FRAC_BITS{1'b0}}};
            dvd_y    <= {q_ny[NUM_W-1] ? NUM_W'(-q_ny) : NUM_W'(q_ny), {FRAC_BITS{1'b0}}};
            rem_x    <= '0;
            rem_y    <= '0;
            neg_x    <= q_nx[NUM_W-1] ^ q_den[DEN_W-1];
            neg_y    <= q_ny[NUM_W-1] ^ q_den[DEN_W-1];
            sgn_nx   <= q_nx[NUM_W-1];
            sgn_ny   <= q_ny[NUM_W-1];
            nz_nx    <= (q_nx != '0);
            nz_ny    <= (q_ny != '0);
            iter     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle, quotient shifts into the dividend
          sx = {rem_x[DEN_W-1:0], dvd_x[DVD_W-1]};
          sy = {rem_y[DEN_W-1:0], dvd_y[DVD_W-1]};
          if (sx >= {1'b0, dmag}) begin
            rem_x <= sx - {1'b0, dmag};
            dvd_x <= {dvd_x[DVD_W-2:0], 1'b1};
          end else begin
            rem_x <= sx;
            dvd_x <= {dvd_x[DVD_W-2:0], 1'b0};
          end
          if (sy >= {1'b0, dmag}) begin
            rem_y <= sy - {1'b0, dmag};
            dvd_y <= {dvd_y[DVD_W-2:0], 1'b1};
          end else begin
            rem_y <= sy;
            dvd_y <= {dvd_y[DVD_W-2:0], 1'b0};
          end
          iter <= iter + IT_W'(1);
          if (iter == IT_W'(DVD_W - 1)) state <= S_RD1;
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          ux_old <= ux_rdata;
          uy_old <= uy_rdata;
          state  <= S_CALC;
        end
        S_CALC: begin
          if (proceed) begin
            d = (VEL_W+3)'(ux) - (VEL_W+3)'($signed(ux_old[VEL_W-1:0]))
              - (VEL_W+3)'($signed(uy_rdata[VEL_W-1:0])) + (VEL_W+3)'(uy_delay);
            if (ctl.emit) begin
              out_valid     <= 1'b1;
              vort_value    <= VORT_W'(d >>> 1);
              density_fault <= den_zero | ux_old[VEL_W] | uy_rdata[VEL_W] | fy_delay;
              frame_last    <= ctl.last;
            end
            uy_delay <= $signed(uy_old[VEL_W-1:0]);
            fy_delay <= uy_old[VEL_W];
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/lattice_vorticity_stencil_unit.sv]
// Top level of the lattice vorticity stencil: front, queue and back.
// Depends on lvs_pkg, lvs_front, lvs_queue, lvs_back.
//
//   channel | handshake               | payload
//   in      | in_valid / in_stall     | pop_01 .. pop_19
//   out     | out_valid / out_stall   | vort_value, density_fault, frame_last
//   cfg     | cfg_we                  | cfg_index, cfg_data
//
// Each node passes through the back end one at a time: the idle step that
// pops it from the queue, the bit-serial divider, two line store reads and
// the write-back. The front takes a node per cycle while the queue (two
// entries) has room. Reset is synchronous; no store clearing is needed.
// A stalled result holds the back end in its write-back step.
module lattice_vorticity_stencil_unit import lvs_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int POP_BITS  = POP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [POP_BITS-1:0] pop_01,
  input  logic signed [POP_BITS-1:0] pop_03,
  input  logic signed [POP_BITS-1:0] pop_05,
  input  logic signed [POP_BITS-1:0] pop_08,
  input  logic signed [POP_BITS-1:0] pop_10,
  input  logic signed [POP_BITS-1:0] pop_12,
  input  logic signed [POP_BITS-1:0] pop_14,
  input  logic signed [POP_BITS-1:0] pop_17,
  input  logic signed [POP_BITS-1:0] pop_19,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VORT_W-1:0]   vort_value,
  output logic                       density_fault,
  output logic                       frame_last
);
  localparam int NUM_W = POP_BITS + 3;
  localparam int DEN_W = POP_BITS + 4;
  localparam int CTL_W = $bits(node_ctl_t);
  localparam int QW    = CTL_W + DEN_W + 2 * NUM_W;

  logic signed [POP_BITS-1:0] pops [9];
  node_ctl_t               f_ctl, q_ctl;
  logic signed [DEN_W-1:0] f_den, q_den;
  logic signed [NUM_W-1:0] f_nx, f_ny, q_nx, q_ny;
  logic                    accept, q_full, q_empty, q_pop;
  logic [QW-1:0]           q_out;

  assign pops = '{pop_01, pop_03, pop_05, pop_08, pop_10, pop_12, pop_14, pop_17, pop_19};
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  lvs_front #(.MAX_WIDTH(MAX_WIDTH), .POP_BITS(POP_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .accept(accept), .pops(pops),
    .ctl(f_ctl), .den(f_den), .nx(f_nx), .ny(f_ny)
  );

  lvs_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst), .push(accept),
    .push_data({f_ctl, f_den, f_nx, f_ny}),
    .pop(q_pop), .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  assign {q_ctl, q_den, q_nx, q_ny} = q_out;

  lvs_back #(.MAX_WIDTH(MAX_WIDTH), .POP_BITS(POP_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_ctl(q_ctl), .q_den(q_den),
    .q_nx(q_nx), .q_ny(q_ny), .q_pop(q_pop), .out_valid(out_valid),
    .out_stall(out_stall), .vort_value(vort_value),
    .density_fault(density_fault), .frame_last(frame_last)
  );
endmodule

[design/lvs_checker.sv]
// Port-level checks for the lattice vorticity stencil, bound to the top.
// Depends on lvs_pkg.
module lvs_checker import lvs_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [VORT_W-1:0] vort_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vort_value))
    else $error("result dropped or changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs active right after reset");

  a_no_fast_result: assert property (@(posedge clk)
    $rose(out_valid) |-> !$past(rst) && !$past(rst, 2))
    else $error("result appeared too soon after reset");
endmodule

bind lattice_vorticity_stencil_unit lvs_checker u_lvs_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .vort_value(vort_value)
);
